/* design/rfds_pkg.sv */
// Shared types, codes and arithmetic helpers of the ring field diffusion store.
package rfds_pkg;

  localparam int DATA_W     = 32;
  localparam int LEN_CFG_W  = 9;
  localparam int FACT_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int DEF_CELLS      = 256;
  localparam int DEF_MAX_RADIUS = 127;

  // Shared multiplier and accumulator widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;

  localparam logic [FACT_W-1:0] Q16_ONE = 17'd65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_MIX  = 2'd2;

  // Operation kinds.
  localparam logic [2:0] KIND_READ     = 3'd0;
  localparam logic [2:0] KIND_WRITE    = 3'd1;
  localparam logic [2:0] KIND_DEPOSIT  = 3'd2;
  localparam logic [2:0] KIND_FILL     = 3'd3;
  localparam logic [2:0] KIND_DECAY    = 3'd4;
  localparam logic [2:0] KIND_DIFFUSE  = 3'd5;
  localparam logic [2:0] KIND_MEAN     = 3'd6;
  localparam logic [2:0] KIND_GRADIENT = 3'd7;

  // Pointer updates.
  localparam logic [3:0] PTR_HOLD  = 4'd0;
  localparam logic [3:0] PTR_ZERO  = 4'd1;
  localparam logic [3:0] PTR_INC   = 4'd2;
  localparam logic [3:0] PTR_STEP  = 4'd3;
  localparam logic [3:0] PTR_IDX   = 4'd4;
  localparam logic [3:0] PTR_LAST  = 4'd5;
  localparam logic [3:0] PTR_RIGHT = 4'd6;
  localparam logic [3:0] PTR_LEFT  = 4'd7;
  localparam logic [3:0] PTR_START = 4'd8;

  // Write data selection.
  localparam logic [2:0] WR_ZERO  = 3'd0;
  localparam logic [2:0] WR_VAL   = 3'd1;
  localparam logic [2:0] WR_DEP   = 3'd2;
  localparam logic [2:0] WR_DECAY = 3'd3;
  localparam logic [2:0] WR_DIFF  = 3'd4;

  // Multiplier operations.
  localparam logic [1:0] MUL_NONE  = 2'd0;
  localparam logic [1:0] MUL_DECAY = 2'd1;
  localparam logic [1:0] MUL_SELF  = 2'd2;
  localparam logic [1:0] MUL_NEIGH = 2'd3;

  // Divider operand selection.
  localparam logic [1:0] DIV_IDX = 2'd0;
  localparam logic [1:0] DIV_RAD = 2'd1;
  localparam logic [1:0] DIV_SUM = 2'd2;

  // Result selection.
  localparam logic [2:0] RES_ZERO  = 3'd0;
  localparam logic [2:0] RES_ERR   = 3'd1;
  localparam logic [2:0] RES_RDATA = 3'd2;
  localparam logic [2:0] RES_GRAD  = 3'd3;
  localparam logic [2:0] RES_MEAN  = 3'd4;

  typedef struct packed {
    logic [2:0]               kind;
    logic [7:0]               cell_index;
    logic signed [DATA_W-1:0] operand_value;
    logic [6:0]               window_radius;
  } item_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     index_error;
  } item_out_t;

  typedef struct packed {
    logic       op_load;
    logic [3:0] ptr_op;
    logic       rd_next;
    logic       we;
    logic [2:0] wsel;
    logic [1:0] mul_op;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cen_load;
    logic       prev_load;
    logic       cur_load;
    logic       nxt_load;
    logic       win_shift;
    logic       hold_load;
    logic       sum_clr;
    logic       sum_acc;
    logic       res_load;
    logic [2:0] res_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       len_zero;
    logic       len_short;
    logic       idx_bad;
    logic       ptr_last;
    logic       clr_last;
    logic       win_last;
    logic       div_done;
  } status_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if ((&top) || (~|top)) begin
      sat32 = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat32 = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // Divide by 2^n, rounding to nearest with ties toward plus infinity.
  function automatic logic signed [ACC_W-1:0] round_shift(input logic signed [ACC_W-1:0] v,
                                                          input int unsigned n);
    logic signed [ACC_W-1:0] bias;
    bias = '0;
    bias[n-1] = 1'b1;
    round_shift = (v + bias) >>> n;
  endfunction

endpackage

/* design/ring_field_diffusion_store.sv */
// Top level of the ring field diffusion store: controller, datapath and port wiring.
// Usage: the block holds a ring of signed Q16.16 cells and runs one operation per
// input item (read, write, deposit, fill, decay, diffuse, window mean, gradient).
// The input channel (in_valid, in_ready, in_item) takes one item at a time; the
// result channel (out_valid, out_ready, out_item) returns exactly one item for each.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready and writes ring_length, decay_factor or diffuse_mix; an unused index is dropped.
// Fill, decay and diffuse sweep the L live cells; gradient and window mean use the
// shared bit-serial divider (one quotient bit a cycle). The cell memory's one write
// port, its registered read port and the shared multiplier set the per-cell sweeps.
// After reset every cell is cleared to zero in a pass of one cell a cycle, during
// which no item is accepted; configuration writes are taken throughout.
// The result sits in an output register: a stalled receiver holds it there while the
// next item is already accepted and worked on, and only its completion then waits.
module ring_field_diffusion_store import rfds_pkg::*; #(
  parameter int CELLS      = DEF_CELLS,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  item_in_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output item_out_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Always ready; the user must see that writes are only made while idle, unenforced.
  assign cfg_ready = 1'b1;

  rfds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rfds_dpath #(
    .CELLS      (CELLS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule

/* design/rfds_div.sv */
// Restoring divider producing one quotient bit per cycle.
module rfds_div import rfds_pkg::*; #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  localparam int CW = $clog2(NUM_W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           take;
  logic [DEN_W-1:0] rem_next;

  assign trial    = {remainder, quotient[NUM_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign take     = (trial >= {1'b0, divisor});
  assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[NUM_W-2:0], take};
      remainder <= rem_next;
    end
  end

endmodule

/* design/rfds_dpath.sv */
// Datapath: cell memory, configuration registers, multiplier, divider and result registers.
module rfds_dpath import rfds_pkg::*; #(
  parameter int CELLS      = DEF_CELLS,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  item_in_t              in_item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output status_t               status,
  output item_out_t             out_item
);

  localparam int AW = $clog2(CELLS);
  localparam int LW = $clog2(CELLS + 1);
  localparam int WW = $clog2(2 * MAX_RADIUS + 2);
  localparam int RW = $clog2(MAX_RADIUS + 2);
  localparam int SW = 33 + WW;
  localparam int VW = (LW > WW) ? LW : WW;

  // Configuration registers.
  logic [LEN_CFG_W-1:0] ring_len;
  logic [FACT_W-1:0]    decay_f;
  logic [FACT_W-1:0]    mix_f;

  // Captured item.
  logic [2:0]               op_kind;
  logic [7:0]               op_idx;
  logic signed [DATA_W-1:0] op_val;
  logic [RW-1:0]            rad;

  logic [AW-1:0]            ptr;
  logic [AW-1:0]            ptr_next;
  logic [AW-1:0]            cen;
  logic signed [DATA_W-1:0] prev;
  logic signed [DATA_W-1:0] cur;
  logic signed [DATA_W-1:0] nxt;
  logic signed [DATA_W-1:0] wrap_r;
  logic signed [DATA_W-1:0] hold;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SW-1:0]     sum;
  logic [WW-1:0]            cnt;
  logic signed [DATA_W-1:0] res_value;
  logic                     res_err;

  logic [DATA_W-1:0]        mem [CELLS];
  logic signed [DATA_W-1:0] mem_q;
  logic [AW-1:0]            raddr;
  logic signed [DATA_W-1:0] wdata;

  logic [LW-1:0]            len;
  logic [AW-1:0]            last_addr;
  logic [AW-1:0]            ptr_inc;
  logic [AW-1:0]            right_addr;
  logic [AW-1:0]            left_addr;
  logic [LW:0]              start_pos;
  logic [FACT_W-1:0]        f_clamp;
  logic [FACT_W-1:0]        m_clamp;
  logic [WW-1:0]            win;
  logic [SW-1:0]            sum_mag;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  logic             div_done;
  logic [SW-1:0]    div_num;
  logic [VW-1:0]    div_den;
  logic [SW-1:0]    div_quo;
  logic [VW-1:0]    div_rem;
  logic signed [ACC_W-1:0] mean_val;

  // Derived ring quantities.
  assign len = (32'(ring_len) > 32'(CELLS)) ? LW'(CELLS) : LW'(ring_len);
  assign last_addr  = AW'(len - LW'(1));
  assign ptr_inc    = (ptr == last_addr) ? '0 : ptr + AW'(1);
  assign right_addr = (cen == last_addr) ? '0 : cen + AW'(1);
  assign left_addr  = (cen == '0) ? last_addr : cen - AW'(1);
  assign start_pos  = (32'(cen) >= 32'(div_rem))
                    ? (LW + 1)'(cen) - (LW + 1)'(div_rem)
                    : (LW + 1)'(cen) + (LW + 1)'(len) - (LW + 1)'(div_rem);
  assign f_clamp = (decay_f > Q16_ONE) ? Q16_ONE : decay_f;
  assign m_clamp = (mix_f > Q16_ONE) ? Q16_ONE : mix_f;
  assign win     = WW'({rad, 1'b1});
  assign sum_mag = sum[SW-1] ? SW'(-sum) : SW'(sum);

  always_comb begin
    status.kind      = op_kind;
    status.len_zero  = (len == '0);
    status.len_short = (32'(len) < 32'd2);
    status.idx_bad   = (32'(op_idx) >= 32'(len));
    status.ptr_last  = (ptr == last_addr);
    status.clr_last  = (32'(ptr) == 32'(CELLS - 1));
    status.win_last  = (cnt == WW'({rad, 1'b0}));
    status.div_done  = div_done;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_len <= LEN_CFG_W'(256);
      decay_f  <= Q16_ONE;
      mix_f    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RING_LENGTH:  ring_len <= cfg_data[LEN_CFG_W-1:0];
        REG_DECAY_FACTOR: decay_f  <= cfg_data[FACT_W-1:0];
        REG_DIFFUSE_MIX:  mix_f    <= cfg_data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture; the radius is limited here once.
  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      op_kind <= in_item.kind;
      op_idx  <= in_item.cell_index;
      op_val  <= in_item.operand_value;
      rad     <= (32'(in_item.window_radius) > 32'(MAX_RADIUS))
               ? RW'(MAX_RADIUS) : RW'(in_item.window_radius);
    end
  end

  always_comb begin
    case (cmd.ptr_op)
      PTR_ZERO:  ptr_next = '0;
      PTR_INC:   ptr_next = ptr_inc;
      PTR_STEP:  ptr_next = ptr + AW'(1);
      PTR_IDX:   ptr_next = AW'(op_idx);
      PTR_LAST:  ptr_next = last_addr;
      PTR_RIGHT: ptr_next = right_addr;
      PTR_LEFT:  ptr_next = left_addr;
      PTR_START: ptr_next = AW'(start_pos);
      default:   ptr_next = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      ptr <= ptr_next;
    end
  end

  // Cell memory: one write port and one registered read port.
  assign raddr = cmd.rd_next ? ptr + AW'(1) : ptr;

  always_comb begin
    case (cmd.wsel)
      WR_VAL:   wdata = op_val;
      WR_DEP:   wdata = sat32(ACC_W'(mem_q) + ACC_W'(op_val));
      WR_DECAY: wdata = sat32(round_shift(ACC_W'(prod), 16));
      WR_DIFF:  wdata = sat32(round_shift(acc + ACC_W'(prod), 17));
      default:  wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[ptr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // Shared multiplier with a product register.
  always_comb begin
    case (cmd.mul_op)
      MUL_DECAY: begin
        mul_a = MUL_A_W'(mem_q);
        mul_b = MUL_B_W'({1'b0, f_clamp});
      end
      MUL_SELF: begin
        mul_a = MUL_A_W'(cur);
        mul_b = MUL_B_W'({1'b0, Q16_ONE - m_clamp});
      end
      MUL_NEIGH: begin
        mul_a = MUL_A_W'(prev) + MUL_A_W'(nxt);
        mul_b = MUL_B_W'({1'b0, m_clamp});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.mul_op == MUL_NEIGH) begin
      acc <= ACC_W'(prod) <<< 1;
    end
  end

  // Window and neighbour registers.
  always_ff @(posedge clk) begin
    if (cmd.cen_load) begin
      cen <= AW'(div_rem);
    end
    if (cmd.prev_load) begin
      prev <= mem_q;
    end else if (cmd.win_shift) begin
      prev <= cur;
    end
    if (cmd.cur_load) begin
      cur    <= mem_q;
      wrap_r <= mem_q;
    end else if (cmd.win_shift) begin
      cur <= nxt;
    end
    if (cmd.nxt_load) begin
      nxt <= status.ptr_last ? wrap_r : mem_q;
    end
    if (cmd.hold_load) begin
      hold <= mem_q;
    end
    if (cmd.sum_clr) begin
      sum <= '0;
      cnt <= '0;
    end else if (cmd.sum_acc) begin
      sum <= sum + SW'(mem_q);
      cnt <= cnt + WW'(1);
    end
  end

  // Shared divider for both modulo reductions and the mean.
  always_comb begin
    case (cmd.div_sel)
      DIV_RAD: begin
        div_num = SW'(rad);
        div_den = VW'(len);
      end
      DIV_SUM: begin
        div_num = sum_mag + SW'(rad);
        div_den = VW'(win);
      end
      default: begin
        div_num = SW'(op_idx);
        div_den = VW'(len);
      end
    endcase
  end

  rfds_div #(
    .NUM_W (SW),
    .DEN_W (VW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign mean_val = sum[SW-1] ? -ACC_W'(div_quo) : ACC_W'(div_quo);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_ERR: begin
          res_value <= '0;
          res_err   <= 1'b1;
        end
        RES_RDATA: begin
          res_value <= mem_q;
          res_err   <= 1'b0;
        end
        RES_GRAD: begin
          res_value <= sat32(ACC_W'(hold) - ACC_W'(mem_q));
          res_err   <= 1'b0;
        end
        RES_MEAN: begin
          res_value <= sat32(mean_val);
          res_err   <= 1'b0;
        end
        default: begin
          res_value <= '0;
          res_err   <= 1'b0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_item.result_value <= res_value;
      out_item.index_error  <= res_err;
    end
  end

endmodule

/* design/rfds_ctrl.sv */
// Controller state machine sequencing every operation over the datapath.
module rfds_ctrl import rfds_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DISP   = 5'd2;
  localparam logic [4:0] S_PT_RD  = 5'd3;
  localparam logic [4:0] S_PT_EX  = 5'd4;
  localparam logic [4:0] S_FILL   = 5'd5;
  localparam logic [4:0] S_DC_RD  = 5'd6;
  localparam logic [4:0] S_DC_MUL = 5'd7;
  localparam logic [4:0] S_DC_WR  = 5'd8;
  localparam logic [4:0] S_DF_A   = 5'd9;
  localparam logic [4:0] S_DF_B   = 5'd10;
  localparam logic [4:0] S_DF_C   = 5'd11;
  localparam logic [4:0] S_DF_RDN = 5'd12;
  localparam logic [4:0] S_DF_M1  = 5'd13;
  localparam logic [4:0] S_DF_M2  = 5'd14;
  localparam logic [4:0] S_DF_WR  = 5'd15;
  localparam logic [4:0] S_GR_DIV = 5'd16;
  localparam logic [4:0] S_GR_SET = 5'd17;
  localparam logic [4:0] S_GR_R   = 5'd18;
  localparam logic [4:0] S_GR_RD  = 5'd19;
  localparam logic [4:0] S_GR_L   = 5'd20;
  localparam logic [4:0] S_GR_LD  = 5'd21;
  localparam logic [4:0] S_MN_D1  = 5'd22;
  localparam logic [4:0] S_MN_D2  = 5'd23;
  localparam logic [4:0] S_MN_RD  = 5'd24;
  localparam logic [4:0] S_MN_ACC = 5'd25;
  localparam logic [4:0] S_MN_DV0 = 5'd26;
  localparam logic [4:0] S_MN_DW  = 5'd27;
  localparam logic [4:0] S_FIN    = 5'd28;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLR: begin
        cmd.we     = 1'b1;
        cmd.wsel   = WR_ZERO;
        cmd.ptr_op = PTR_STEP;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op_load = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_ZERO;
        unique case (status.kind) inside
          KIND_READ, KIND_WRITE, KIND_DEPOSIT: begin
            if (status.idx_bad) begin
              cmd.res_sel = RES_ERR;
              state_next  = S_FIN;
            end else begin
              cmd.ptr_op = PTR_IDX;
              state_next = S_PT_RD;
            end
          end
          KIND_FILL: begin
            cmd.ptr_op = PTR_ZERO;
            state_next = status.len_zero ? S_FIN : S_FILL;
          end
          KIND_DECAY: begin
            cmd.ptr_op = PTR_ZERO;
            state_next = status.len_zero ? S_FIN : S_DC_RD;
          end
          KIND_DIFFUSE: begin
            cmd.ptr_op = PTR_LAST;
            state_next = status.len_short ? S_FIN : S_DF_A;
          end
          KIND_MEAN: begin
            cmd.div_start = !status.len_zero;
            cmd.div_sel   = DIV_IDX;
            state_next    = status.len_zero ? S_FIN : S_MN_D1;
          end
          default: begin
            cmd.div_start = !status.len_zero;
            cmd.div_sel   = DIV_IDX;
            state_next    = status.len_zero ? S_FIN : S_GR_DIV;
          end
        endcase
      end
      S_PT_RD: begin
        state_next = S_PT_EX;
      end
      S_PT_EX: begin
        unique case (status.kind) inside
          KIND_WRITE: begin
            cmd.we   = 1'b1;
            cmd.wsel = WR_VAL;
          end
          KIND_DEPOSIT: begin
            cmd.we   = 1'b1;
            cmd.wsel = WR_DEP;
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_RDATA;
          end
        endcase
        state_next = S_FIN;
      end
      S_FILL: begin
        cmd.we   = 1'b1;
        cmd.wsel = WR_VAL;
        if (status.ptr_last) begin
          state_next = S_FIN;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_DC_RD: begin
        state_next = S_DC_MUL;
      end
      S_DC_MUL: begin
        cmd.mul_op = MUL_DECAY;
        state_next = S_DC_WR;
      end
      S_DC_WR: begin
        cmd.we   = 1'b1;
        cmd.wsel = WR_DECAY;
        if (status.ptr_last) begin
          state_next = S_FIN;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_next = S_DC_RD;
        end
      end
      S_DF_A: begin
        cmd.ptr_op = PTR_ZERO;
        state_next = S_DF_B;
      end
      S_DF_B: begin
        cmd.prev_load = 1'b1;
        state_next    = S_DF_C;
      end
      S_DF_C: begin
        cmd.cur_load = 1'b1;
        state_next   = S_DF_RDN;
      end
      S_DF_RDN: begin
        cmd.rd_next = 1'b1;
        state_next  = S_DF_M1;
      end
      S_DF_M1: begin
        cmd.nxt_load = 1'b1;
        cmd.mul_op   = MUL_SELF;
        state_next   = S_DF_M2;
      end
      S_DF_M2: begin
        cmd.mul_op = MUL_NEIGH;
        state_next = S_DF_WR;
      end
      S_DF_WR: begin
        cmd.we        = 1'b1;
        cmd.wsel      = WR_DIFF;
        cmd.win_shift = 1'b1;
        if (status.ptr_last) begin
          state_next = S_FIN;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_next = S_DF_RDN;
        end
      end
      S_GR_DIV: begin
        if (status.div_done) begin
          cmd.cen_load = 1'b1;
          state_next   = S_GR_SET;
        end
      end
      S_GR_SET: begin
        cmd.ptr_op = PTR_RIGHT;
        state_next = S_GR_R;
      end
      S_GR_R: begin
        state_next = S_GR_RD;
      end
      S_GR_RD: begin
        cmd.hold_load = 1'b1;
        cmd.ptr_op    = PTR_LEFT;
        state_next    = S_GR_L;
      end
      S_GR_L: begin
        state_next = S_GR_LD;
      end
      S_GR_LD: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_GRAD;
        state_next   = S_FIN;
      end
      S_MN_D1: begin
        if (status.div_done) begin
          cmd.cen_load  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RAD;
          state_next    = S_MN_D2;
        end
      end
      S_MN_D2: begin
        if (status.div_done) begin
          cmd.ptr_op  = PTR_START;
          cmd.sum_clr = 1'b1;
          state_next  = S_MN_RD;
        end
      end
      S_MN_RD: begin
        state_next = S_MN_ACC;
      end
      S_MN_ACC: begin
        cmd.sum_acc = 1'b1;
        cmd.ptr_op  = PTR_INC;
        state_next  = status.win_last ? S_MN_DV0 : S_MN_RD;
      end
      S_MN_DV0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SUM;
        state_next    = S_MN_DW;
      end
      S_MN_DW: begin
        cmd.div_sel = DIV_SUM;
        if (status.div_done) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_MEAN;
          state_next   = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the ring field diffusion store, with a built-in predictor.
`timescale 1ns / 100ps

module testbench;
  import rfds_pkg::*;

  // The clock runs at 100 MHz. Reset is held at the start of the run.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  item_in_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  item_out_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ring_field_diffusion_store u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // This is the predictor's own copy of the ring and of the three registers.
  logic signed [31:0] cell_shadow [DEF_CELLS];
  logic [8:0]         len_reg;
  logic [16:0]        decay_reg;
  logic [16:0]        mix_reg;

  item_out_t   pending_results[$];
  int          error_count = 0;
  int          result_count = 0;
  int          item_count = 0;
  int          idle_cycles = 0;
  int unsigned stall_pattern = 32'h0;

  // These functions follow the block's fixed-point rules: saturation to 32 bits, and
  // division by a power of two with rounding to nearest and ties toward plus infinity.
  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint shift_round(longint p, int n);
    return (p + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic int live_cells();
    return (len_reg > DEF_CELLS) ? DEF_CELLS : int'(len_reg);
  endfunction

  // Apply one item to the shadow ring and return the result the block should produce.
  function automatic item_out_t predict_field_op(item_in_t it);
    item_out_t          r;
    int                 n, c, lft, rgt, w, pos;
    longint             f, m, acc, s, mag, q;
    logic signed [31:0] snap [DEF_CELLS];
    r = '0;
    n = live_cells();
    case (it.kind)
      KIND_READ, KIND_WRITE, KIND_DEPOSIT: begin
        if (it.cell_index >= n) begin
          r.index_error = 1'b1;
        end else if (it.kind == KIND_READ) begin
          r.result_value = cell_shadow[it.cell_index];
        end else if (it.kind == KIND_WRITE) begin
          cell_shadow[it.cell_index] = it.operand_value;
        end else begin
          cell_shadow[it.cell_index] =
            clip32(longint'(cell_shadow[it.cell_index]) + longint'(it.operand_value));
        end
      end
      KIND_FILL: begin
        for (int i = 0; i < n; i++) cell_shadow[i] = it.operand_value;
      end
      KIND_DECAY: begin
        f = (decay_reg > 65536) ? 65536 : decay_reg;
        for (int i = 0; i < n; i++)
          cell_shadow[i] = clip32(shift_round(longint'(cell_shadow[i]) * f, 16));
      end
      KIND_DIFFUSE: begin
        m = (mix_reg > 65536) ? 65536 : mix_reg;
        if (n >= 2) begin
          snap = cell_shadow;
          for (int i = 0; i < n; i++) begin
            lft = (i == 0) ? n - 1 : i - 1;
            rgt = (i + 1 == n) ? 0 : i + 1;
            acc = 2 * longint'(snap[i]) * (65536 - m)
                + m * (longint'(snap[lft]) + longint'(snap[rgt]));
            cell_shadow[i] = clip32(shift_round(acc, 17));
          end
        end
      end
      KIND_MEAN: begin
        if (n != 0) begin
          w = 2 * int'(it.window_radius) + 1;
          pos = (int'(it.cell_index) % n + n - (int'(it.window_radius) % n)) % n;
          s = 0;
          for (int k = 0; k < w; k++) begin
            s += longint'(cell_shadow[pos]);
            pos = (pos + 1 == n) ? 0 : pos + 1;
          end
          // The quotient is rounded to nearest, with ties away from zero.
          mag = (s < 0) ? -s : s;
          q = (mag + w / 2) / w;
          r.result_value = clip32((s < 0) ? -q : q);
        end
      end
      default: begin
        if (n != 0) begin
          c = int'(it.cell_index) % n;
          lft = (c == 0) ? n - 1 : c - 1;
          rgt = (c + 1 == n) ? 0 : c + 1;
          r.result_value = clip32(longint'(cell_shadow[rgt]) - longint'(cell_shadow[lft]));
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", result_count, what, got, want);
    error_count++;
  endtask

  // The checker takes each accepted result and compares it with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", out_item.result_value, 32'h0);
      end else begin
        item_out_t want;
        want = pending_results.pop_front();
        if (out_item.result_value !== want.result_value)
          report_mismatch("result_value", out_item.result_value, want.result_value);
        if (out_item.index_error !== want.index_error)
          report_mismatch("index_error", 32'(out_item.index_error), 32'(want.index_error));
      end
      result_count++;
    end
  end

  // The receiver stalls on a rotating pattern. The pattern changes now and then, and
  // all-ones gives stretches with no stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = 32'hffffffff;
          1: stall_pattern = $urandom;
          2: stall_pattern = 32'h0f0f0f0f;
          default: stall_pattern = 32'h11111111;
        endcase
      end
      stall_pattern = {stall_pattern[30:0], stall_pattern[31]};
      out_ready <= stall_pattern[0];
    end
  end

  // The watchdog counts cycles with no handshake on any channel. Its limit leaves
  // wide margin over the longest sweeps, such as a diffuse over 256 cells, and over the
  // clearing pass after reset.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // The sender works in bursts. Before each burst it may leave a random gap.
  int burst_left = 0;

  task automatic send_item(item_in_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_field_op(it));
    item_count++;
    in_valid <= 1'b0;
    // The block is busy right after an accepted item, so this edge costs no throughput.
    @(posedge clk);
  endtask

  task automatic send_op(logic [2:0] k, int idx, logic [31:0] v, int rad);
    item_in_t it;
    it.kind = k;
    it.cell_index = 8'(idx);
    it.operand_value = v;
    it.window_radius = 7'(rad);
    send_item(it);
  endtask

  // Wait until every result is back, then let the block settle before a register write.
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RING_LENGTH:  len_reg = d[8:0];
      REG_DECAY_FACTOR: decay_reg = d;
      REG_DIFFUSE_MIX:  mix_reg = d;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(int n, int f, int m);
    drain();
    write_reg(REG_RING_LENGTH, CFG_DATA_W'(n));
    write_reg(REG_DECAY_FACTOR, CFG_DATA_W'(f));
    write_reg(REG_DIFFUSE_MIX, CFG_DATA_W'(m));
  endtask

  // These directed items cover the field extremes, every kind, saturation, and bad indexes.
  task automatic test_directed();
    send_op(KIND_READ, 0, 0, 0);
    send_op(KIND_WRITE, 255, 32'h7fffffff, 0);
    send_op(KIND_DEPOSIT, 255, 32'h7fffffff, 0);
    send_op(KIND_READ, 255, 0, 0);
    send_op(KIND_WRITE, 0, 32'h80000000, 0);
    send_op(KIND_DEPOSIT, 0, 32'h80000000, 0);
    send_op(KIND_GRADIENT, 255, 0, 0);
    send_op(KIND_GRADIENT, 0, 0, 0);
    send_op(KIND_MEAN, 0, 0, 127);
    send_op(KIND_MEAN, 128, 0, 0);
    send_op(KIND_DIFFUSE, 0, 0, 0);
    send_op(KIND_FILL, 7, 32'hffff_8000, 0);
    send_op(KIND_DECAY, 0, 0, 0);
    send_op(KIND_MEAN, 3, 0, 1);
    // With a short ring, bad indexes are flagged and wide windows count cells again.
    set_regs(5, 32768, 65536);
    send_op(KIND_WRITE, 5, 32'h1234, 0);
    send_op(KIND_READ, 200, 0, 0);
    send_op(KIND_DEPOSIT, 4, 32'h00018000, 0);
    send_op(KIND_DECAY, 0, 0, 0);
    send_op(KIND_DIFFUSE, 0, 0, 0);
    send_op(KIND_MEAN, 250, 0, 127);
    // The values above the register ranges act as the largest legal values.
    set_regs(1, 131071, 131071);
    send_op(KIND_DIFFUSE, 0, 0, 0);
    send_op(KIND_GRADIENT, 0, 0, 0);
    set_regs(0, 0, 0);
    send_op(KIND_MEAN, 9, 0, 3);
    send_op(KIND_GRADIENT, 9, 0, 0);
    send_op(KIND_WRITE, 0, 1, 0);
    send_op(KIND_DECAY, 0, 0, 0);
  endtask

  // Random items are drawn against several ring settings. Most phases use short rings so
  // the sweeps stay quick, and a few phases use the full ring.
  task automatic test_random(int count);
    item_in_t it;
    int       n;
    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0: n = 256;
        1: n = $urandom_range(2, 16);
        2: n = $urandom_range(300, 511);
        3: n = $urandom_range(0, 3);
        default: n = $urandom_range(17, 64);
      endcase
      set_regs(n, $urandom_range(0, 131071), $urandom_range(0, 131071));
      for (int i = 0; i < count / 10; i++) begin
        it.kind = 3'($urandom_range(0, 7));
        // Full-ring sweeps are kept rare so that the run stays short.
        if (n > 64 && it.kind inside {KIND_FILL, KIND_DECAY, KIND_DIFFUSE}
            && $urandom_range(0, 3) != 0)
          it.kind = KIND_READ;
        it.cell_index = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, n));
        case ($urandom_range(0, 3))
          0: it.operand_value = $urandom;
          1: it.operand_value = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
          default: it.operand_value = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        endcase
        it.window_radius = ($urandom_range(0, 4) == 0) ? 7'($urandom)
                                                       : 7'($urandom_range(0, 6));
        send_item(it);
      end
    end
  endtask

  initial begin
    len_reg = 9'd256;
    decay_reg = 17'd65536;
    mix_reg = '0;
    foreach (cell_shadow[i]) cell_shadow[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1250);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d items and %0d results over ten ring settings", item_count,
             result_count);
    $display("mismatches counted: %0d", error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* ring_field_diffusion_store.f */
design/rfds_pkg.sv
design/rfds_div.sv
design/rfds_dpath.sv
design/rfds_ctrl.sv
design/ring_field_diffusion_store.sv
tb/testbench.sv
